/* rtl/owtr_pkg.sv */
package owtr_pkg;

  localparam int unsigned CountW = 20;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 20;

  localparam logic [CfgIdxW-1:0] CFG_RESET_LOW      = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_PRESENCE_WAIT  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_RESET_RECOVERY = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_SLOT_START     = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_SLOT_LENGTH    = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_CONVERSION     = 3'd5;

  localparam logic [9:0]        RESET_LOW_DEF      = 10'd480;
  localparam logic [7:0]        PRESENCE_WAIT_DEF  = 8'd60;
  localparam logic [9:0]        RESET_RECOVERY_DEF = 10'd420;
  localparam logic [3:0]        SLOT_START_DEF     = 4'd2;
  localparam logic [7:0]        SLOT_LENGTH_DEF    = 8'd60;
  localparam logic [CountW-1:0] CONVERSION_DEF     = 20'd750000;

  localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
  localparam logic [7:0] CMD_CONVERT  = 8'h44;
  localparam logic [7:0] CMD_READ_PAD = 8'hBE;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_RST_LOW,
    PH_RST_WAIT,
    PH_RST_RECOV,
    PH_WR_START,
    PH_WR_DRIVE,
    PH_CONV,
    PH_RD_START,
    PH_RD_WAIT
  } phase_e;

  typedef enum logic [2:0] {
    STEP_PROBE,
    STEP_RESET_CONV,
    STEP_SKIP_CONV,
    STEP_CONVERT,
    STEP_WAITING,
    STEP_RESET_READ,
    STEP_SKIP_READ,
    STEP_READ_PAD
  } byte_step_e;

  typedef struct packed {
    logic               pull_low;
    logic               reading_valid;
    logic signed [15:0] temperature_sixteenths;
    logic               no_presence;
    logic               converting;
  } result_t;

endpackage

/* rtl/owtr_core.sv */
module owtr_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic                          line_level_i,
  input  logic                          start_request_i,
  input  logic                          cfg_we_i,
  input  logic [owtr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [owtr_pkg::CfgDataW-1:0] cfg_data_i,
  output owtr_pkg::result_t             result_o
);
  import owtr_pkg::*;

  logic [9:0]        reset_low_q, reset_recovery_q;
  logic [7:0]        presence_wait_q, slot_length_q;
  logic [3:0]        slot_start_q;
  logic [CountW-1:0] conversion_q;

  phase_e            phase_q, phase_d;
  byte_step_e        step_q, step_d;
  logic [CountW-1:0] count_q, count_d, count_inc, dur;
  logic [2:0]        bit_pos_q, bit_pos_d;
  logic [7:0]        cmd_q, cmd_d, rd_q, rd_d, low_q, low_d, rd_now;
  logic              pres_q, pres_d, pres_now, high_q, high_d, done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_low_q      <= RESET_LOW_DEF;
      presence_wait_q  <= PRESENCE_WAIT_DEF;
      reset_recovery_q <= RESET_RECOVERY_DEF;
      slot_start_q     <= SLOT_START_DEF;
      slot_length_q    <= SLOT_LENGTH_DEF;
      conversion_q     <= CONVERSION_DEF;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_RESET_LOW:      reset_low_q      <= cfg_data_i[9:0];
        CFG_PRESENCE_WAIT:  presence_wait_q  <= cfg_data_i[7:0];
        CFG_RESET_RECOVERY: reset_recovery_q <= cfg_data_i[9:0];
        CFG_SLOT_START:     slot_start_q     <= cfg_data_i[3:0];
        CFG_SLOT_LENGTH:    slot_length_q    <= cfg_data_i[7:0];
        CFG_CONVERSION:     conversion_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      step_q    <= STEP_PROBE;
      count_q   <= '0;
      bit_pos_q <= '0;
      cmd_q     <= '0;
      rd_q      <= '0;
      low_q     <= '0;
      pres_q    <= 1'b0;
      high_q    <= 1'b0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      step_q    <= step_d;
      count_q   <= count_d;
      bit_pos_q <= bit_pos_d;
      cmd_q     <= cmd_d;
      rd_q      <= rd_d;
      low_q     <= low_d;
      pres_q    <= pres_d;
      high_q    <= high_d;
    end
  end

  // interval length of the current phase
  always_comb begin
    unique case (phase_q)
      PH_RST_LOW:               dur = {{(CountW-10){1'b0}}, reset_low_q};
      PH_RST_WAIT:              dur = {{(CountW-8){1'b0}}, presence_wait_q};
      PH_RST_RECOV:             dur = {{(CountW-10){1'b0}}, reset_recovery_q};
      PH_WR_START, PH_RD_START: dur = {{(CountW-4){1'b0}}, slot_start_q};
      PH_WR_DRIVE, PH_RD_WAIT:  dur = {{(CountW-8){1'b0}}, slot_length_q};
      PH_CONV:                  dur = conversion_q;
      default:                  dur = '0;
    endcase
  end

  assign count_inc = count_q + {{(CountW-1){1'b0}}, 1'b1};
  assign done      = count_inc >= dur;
  assign pres_now  = (count_q == '0) ? line_level_i : pres_q;
  assign rd_now    = (count_q == '0) ? {line_level_i, rd_q[7:1]} : rd_q;

  always_comb begin
    phase_d   = phase_q;
    step_d    = step_q;
    count_d   = done ? '0 : count_inc;
    bit_pos_d = bit_pos_q;
    cmd_d     = cmd_q;
    rd_d      = rd_q;
    low_d     = low_q;
    pres_d    = pres_q;
    high_d    = high_q;
    result_o  = '0;

    unique case (phase_q)
      PH_IDLE: begin
        count_d = count_q;
        if (start_request_i) begin
          step_d  = STEP_PROBE;
          pres_d  = 1'b0;
          phase_d = PH_RST_LOW;
          count_d = '0;
        end
      end
      PH_RST_LOW: begin
        result_o.pull_low = 1'b1;
        if (done) phase_d = PH_RST_WAIT;
      end
      PH_RST_WAIT: begin
        if (done) phase_d = PH_RST_RECOV;
      end
      PH_RST_RECOV: begin
        pres_d = pres_now;
        if (done) begin
          priority if (step_q == STEP_PROBE) begin
            if (pres_now) begin
              result_o.no_presence = 1'b1;
              phase_d = PH_IDLE;
            end else begin
              step_d  = STEP_RESET_CONV;
              phase_d = PH_RST_LOW;
            end
          end else if (step_q == STEP_RESET_CONV) begin
            step_d    = STEP_SKIP_CONV;
            cmd_d     = CMD_SKIP_ROM;
            bit_pos_d = '0;
            phase_d   = PH_WR_START;
          end else begin
            step_d    = STEP_SKIP_READ;
            cmd_d     = CMD_SKIP_ROM;
            bit_pos_d = '0;
            phase_d   = PH_WR_START;
          end
        end
      end
      PH_WR_START: begin
        result_o.pull_low = 1'b1;
        if (done) phase_d = PH_WR_DRIVE;
      end
      PH_WR_DRIVE: begin
        result_o.pull_low = ~cmd_q[0];
        if (done) begin
          cmd_d     = {1'b0, cmd_q[7:1]};
          bit_pos_d = bit_pos_q + 3'd1;
          priority if (bit_pos_q != 3'd7) begin
            phase_d = PH_WR_START;
          end else if (step_q == STEP_SKIP_CONV) begin
            step_d    = STEP_CONVERT;
            cmd_d     = CMD_CONVERT;
            bit_pos_d = '0;
            phase_d   = PH_WR_START;
          end else if (step_q == STEP_CONVERT) begin
            step_d  = STEP_WAITING;
            phase_d = PH_CONV;
          end else if (step_q == STEP_SKIP_READ) begin
            step_d    = STEP_READ_PAD;
            cmd_d     = CMD_READ_PAD;
            bit_pos_d = '0;
            phase_d   = PH_WR_START;
          end else begin
            high_d    = 1'b0;
            rd_d      = '0;
            bit_pos_d = '0;
            phase_d   = PH_RD_START;
          end
        end
      end
      PH_CONV: begin
        result_o.converting = 1'b1;
        if (done) begin
          step_d  = STEP_RESET_READ;
          phase_d = PH_RST_LOW;
        end
      end
      PH_RD_START: begin
        result_o.pull_low = 1'b1;
        if (done) phase_d = PH_RD_WAIT;
      end
      PH_RD_WAIT: begin
        rd_d = rd_now;
        if (done) begin
          bit_pos_d = bit_pos_q + 3'd1;
          priority if (bit_pos_q != 3'd7) begin
            phase_d = PH_RD_START;
          end else if (!high_q) begin
            low_d   = rd_now;
            rd_d    = '0;
            high_d  = 1'b1;
            phase_d = PH_RD_START;
          end else begin
            result_o.reading_valid          = 1'b1;
            result_o.temperature_sixteenths = {rd_now, low_q};
            high_d  = 1'b0;
            step_d  = STEP_PROBE;
            phase_d = PH_IDLE;
          end
        end
      end
      default: begin
        phase_d = PH_IDLE;
        count_d = '0;
      end
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.converting |-> phase_q == PH_CONV)
    else $error("converting flag outside conversion wait");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.reading_valid |-> !result_o.pull_low && high_q)
    else $error("reading delivered outside second byte");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && phase_q == PH_IDLE && !start_request_i |=> phase_q == PH_IDLE)
    else $error("left idle without a start request");

endmodule

/* rtl/one_wire_temperature_reader.sv */
// a result is formed from the accepted tick and registered in the output or skid entry
// throughput: one tick per cycle, limited only by output stall through a two-entry buffer
// every tick gives exactly one result; timing is counted in accepted ticks
// reset: asynchronous, active low; master returns to idle, counters and shifts clear,
// timing registers return to their default values
module one_wire_temperature_reader (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          line_level_i,
  input  logic                          start_request_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          pull_low_o,
  output logic                          reading_valid_o,
  output logic signed [15:0]            temperature_sixteenths_o,
  output logic                          no_presence_o,
  output logic                          converting_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [owtr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [owtr_pkg::CfgDataW-1:0] cfg_data_i
);
  import owtr_pkg::*;

  result_t res, out_q, skid_q;
  logic    out_valid_q, skid_valid_q, accept, load_out;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = skid_valid_q;
  assign accept      = in_valid_i & ~skid_valid_q;
  assign load_out    = ~out_valid_q | ~out_stall_i;

  owtr_core u_core (
    .clk_i,
    .rst_ni,
    .step_i          (accept),
    .line_level_i,
    .start_request_i,
    .cfg_we_i        (cfg_valid_i),
    .cfg_index_i,
    .cfg_data_i,
    .result_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q  <= skid_valid_q | accept;
      skid_valid_q <= 1'b0;
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (accept) begin
      skid_q <= res;
    end
  end

  assign out_valid_o              = out_valid_q;
  assign pull_low_o               = out_q.pull_low;
  assign reading_valid_o          = out_q.reading_valid;
  assign temperature_sixteenths_o = out_q.temperature_sixteenths;
  assign no_presence_o            = out_q.no_presence;
  assign converting_o             = out_q.converting;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held without output entry");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted request lost");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.reading_valid && out_q.no_presence))
    else $error("reading and missing presence in one result");

endmodule
